### hdl/ohm_pkg.sv
// shared types, constants and codes for the open addressing hash map unit
// no dependencies
package ohm_pkg;

  localparam int SLOTS      = 1024;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int LIVE_W     = 11;
  localparam int KEY_BYTES  = (KEY_W + 7) / 8;
  localparam int BCNT_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_GONE  = 2'd2
  } slot_st_t;

  typedef struct packed {
    slot_st_t          st;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
  } slot_t;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_PROBE = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_OUT   = 7'b1000000
  } fsm_t;

endpackage

### hdl/ohm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ohm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

### hdl/open_addressing_hash_map_unit.sv
// top level of the open addressing hash map unit: sequencer, hash unit and slot table
// depends on ohm_pkg and ohm_ram
//
// A 1024-slot key/value table with linear probing and tombstones, handling one
// request at a time. After reset a clearing pass over every slot empties the table
// and in_stall stays high meanwhile. A put, get or remove is accepted in S_IDLE,
// FNV-1a hashed in S_HASH (one multiply by the prime per key byte, on a single
// shared multiplier; skipped when hash_select is 1), then probed through S_READ and
// S_PROBE per slot, since each slot is one registered read of the table memory;
// the result waits in the output register (S_OUT) until taken. A get or remove on an
// empty table goes straight to S_OUT. A clear request sweeps every slot, one per cycle.
module open_addressing_hash_map_unit
  import ohm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]  value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [VAL_W-1:0]  found_value,
  output logic [LIVE_W-1:0] live_entries
);

  fsm_t              state, state_next;
  req_t              req, req_next;
  logic [KEY_W-1:0]  key_r, key_next;
  logic [VAL_W-1:0]  val_r, val_next;
  logic [31:0]       h, h_next;
  logic [BCNT_W-1:0] hcnt, hcnt_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  n, n_next;
  logic [IDX_W-1:0]  tomb, tomb_next;
  logic              have_tomb, have_tomb_next;
  logic [LIVE_W-1:0] live_count, live_next;
  status_t           sts, sts_next;
  logic [VAL_W-1:0]  found, found_next;
  logic              hash_select;

  logic              we;
  logic [IDX_W-1:0]  wa;
  slot_t             wd;
  slot_t             rd;
  logic [7:0]        key_byte;
  logic              last;
  logic              tomb_any;
  logic [IDX_W-1:0]  tomb_at;

  ohm_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (idx),
    .rd  (rd)
  );

  assign key_byte = key_r[{hcnt, 3'b000} +: 8];
  assign last     = (n == IDX_W'(SLOTS - 1));
  assign tomb_any = have_tomb || (rd.st == SLOT_GONE);
  assign tomb_at  = have_tomb ? tomb : idx;

  always_comb begin
    state_next     = state;
    req_next       = req;
    key_next       = key_r;
    val_next       = val_r;
    h_next         = h;
    hcnt_next      = hcnt;
    idx_next       = idx;
    n_next         = n;
    tomb_next      = tomb;
    have_tomb_next = have_tomb;
    live_next      = live_count;
    sts_next       = sts;
    found_next     = found;
    we             = 1'b0;
    wa             = idx;
    wd             = '{st: SLOT_LIVE, key: key_r, val: val_r};
    case (state)
      S_INIT, S_CLEAR: begin
        we     = 1'b1;
        wa     = n;
        wd.st  = SLOT_EMPTY;
        n_next = n + 1'b1;
        if (last) begin
          if (state == S_INIT) begin
            state_next = S_IDLE;
          end else begin
            live_next  = '0;
            sts_next   = STS_OK;
            state_next = S_OUT;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next       = req_t'(req_type);
          key_next       = key;
          val_next       = value;
          found_next     = '0;
          have_tomb_next = 1'b0;
          n_next         = '0;
          h_next         = FNV_BASIS;
          hcnt_next      = '0;
          sts_next       = STS_OK;
          if (req_t'(req_type) == REQ_CLEAR) begin
            state_next = S_CLEAR;
          end else if (req_t'(req_type) != REQ_PUT && live_count == '0) begin
            sts_next   = STS_NOT_FOUND;
            state_next = S_OUT;
          end else if (hash_select) begin
            idx_next   = key[IDX_W-1:0];
            state_next = S_READ;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        // one fnv-1a round per cycle on the shared multiplier
        h_next    = (h ^ {24'd0, key_byte}) * FNV_PRIME;
        hcnt_next = hcnt + 1'b1;
        if (hcnt == BCNT_W'(KEY_BYTES - 1)) begin
          idx_next   = h_next[IDX_W-1:0];
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (req == REQ_PUT) begin
          if (rd.st == SLOT_EMPTY) begin
            we         = 1'b1;
            wa         = tomb_at;
            live_next  = live_count + 1'b1;
            state_next = S_OUT;
          end else if (rd.st == SLOT_LIVE && rd.key == key_r) begin
            we         = 1'b1;
            state_next = S_OUT;
          end else begin
            if (!have_tomb && rd.st == SLOT_GONE) begin
              tomb_next      = idx;
              have_tomb_next = 1'b1;
            end
            if (last) begin
              // whole table visited: reuse a tombstone if one was seen
              if (tomb_any) begin
                we        = 1'b1;
                wa        = tomb_at;
                live_next = live_count + 1'b1;
              end else begin
                sts_next  = STS_FULL;
              end
              state_next = S_OUT;
            end else begin
              idx_next   = idx + 1'b1;
              n_next     = n + 1'b1;
              state_next = S_READ;
            end
          end
        end else begin
          if (rd.st == SLOT_EMPTY) begin
            sts_next   = STS_NOT_FOUND;
            state_next = S_OUT;
          end else if (rd.st == SLOT_LIVE && rd.key == key_r) begin
            sts_next   = STS_OK;
            if (req == REQ_GET) begin
              found_next = rd.val;
            end else begin
              we        = 1'b1;
              wd        = '{st: SLOT_GONE, key: rd.key, val: rd.val};
              live_next = live_count - 1'b1;
            end
            state_next = S_OUT;
          end else if (last) begin
            sts_next   = STS_NOT_FOUND;
            state_next = S_OUT;
          end else begin
            idx_next   = idx + 1'b1;
            n_next     = n + 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      n           <= '0;
      live_count  <= '0;
      hash_select <= 1'b0;
    end else begin
      state      <= state_next;
      n          <= n_next;
      live_count <= live_next;
      if (cfg_we) begin
        hash_select <= cfg_wdata;
      end
    end
    req       <= req_next;
    key_r     <= key_next;
    val_r     <= val_next;
    h         <= h_next;
    hcnt      <= hcnt_next;
    idx       <= idx_next;
    tomb      <= tomb_next;
    have_tomb <= have_tomb_next;
    sts       <= sts_next;
    found     <= found_next;
  end

  assign in_stall     = (state != S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign status       = sts;
  assign found_value  = found;
  assign live_entries = live_count;

endmodule

### tb/tb_open_addressing_hash_map_unit.sv
// self-checking testbench for the open addressing hash map unit
// depends on ohm_pkg and the unit itself; holds its own table model in a scoreboard class
module tb_open_addressing_hash_map_unit
  import ohm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  class hash_map_scoreboard;
    slot_st_t          st_q[SLOTS];
    logic [KEY_W-1:0]  key_q[SLOTS];
    logic [VAL_W-1:0]  val_q[SLOTS];
    int unsigned       live;
    bit                direct_hash;
    logic [1:0]        sts_fifo[$];
    logic [VAL_W-1:0]  val_fifo[$];
    logic [LIVE_W-1:0] live_fifo[$];
    int                errors;
    int                checked;

    function void clear_table();
      foreach (st_q[i]) st_q[i] = SLOT_EMPTY;
      live = 0;
    endfunction

    function logic [31:0] hash_of(logic [KEY_W-1:0] k);
      logic [31:0] h;
      h = FNV_BASIS;
      if (direct_hash) return k[31:0];
      for (int b = 0; b < KEY_BYTES; b++) begin
        h = h ^ {24'd0, k[8*b +: 8]};
        h = h * FNV_PRIME;
      end
      return h;
    endfunction

    // works out the response to one accepted request and updates the table
    function void note_request(logic [1:0] rt, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int idx, tomb;
      bit have_tomb, done;
      logic [1:0] sts;
      logic [VAL_W-1:0] fv;
      sts = STS_OK;
      fv = '0;
      have_tomb = 0;
      done = 0;
      tomb = 0;
      if (rt == REQ_CLEAR) begin
        clear_table();
      end else if (rt == REQ_PUT) begin
        idx = hash_of(k) % SLOTS;
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (st_q[idx] == SLOT_EMPTY) begin
            if (have_tomb) idx = tomb;
            st_q[idx] = SLOT_LIVE;
            key_q[idx] = k;
            val_q[idx] = v;
            live++;
            done = 1;
          end else if (st_q[idx] == SLOT_GONE) begin
            if (!have_tomb) begin
              have_tomb = 1;
              tomb = idx;
            end
          end else if (key_q[idx] == k) begin
            val_q[idx] = v;
            done = 1;
          end
          idx = (idx + 1) % SLOTS;
        end
        if (!done) begin
          if (have_tomb) begin
            st_q[tomb] = SLOT_LIVE;
            key_q[tomb] = k;
            val_q[tomb] = v;
            live++;
          end else begin
            sts = STS_FULL;
          end
        end
      end else begin
        sts = STS_NOT_FOUND;
        if (live != 0) begin
          idx = hash_of(k) % SLOTS;
          for (int i = 0; i < SLOTS; i++) begin
            if (st_q[idx] == SLOT_EMPTY) break;
            if (st_q[idx] == SLOT_LIVE && key_q[idx] == k) begin
              sts = STS_OK;
              if (rt == REQ_GET) begin
                fv = val_q[idx];
              end else begin
                st_q[idx] = SLOT_GONE;
                live--;
              end
              break;
            end
            idx = (idx + 1) % SLOTS;
          end
        end
      end
      sts_fifo.push_back(sts);
      val_fifo.push_back(fv);
      live_fifo.push_back(live[LIVE_W-1:0]);
    endfunction

    function void check_response(logic [1:0] s, logic [VAL_W-1:0] fv, logic [LIVE_W-1:0] le);
      logic [1:0] es;
      logic [VAL_W-1:0] ev;
      logic [LIVE_W-1:0] el;
      if (sts_fifo.size() == 0) begin
        $display("%0t: response with nothing pending: status %0d value %h live %0d",
                 $time, s, fv, le);
        errors++;
        return;
      end
      es = sts_fifo.pop_front();
      ev = val_fifo.pop_front();
      el = live_fifo.pop_front();
      checked++;
      if (s !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, s);
        errors++;
      end
      if (fv !== ev) begin
        $display("%0t: found_value expected %h actual %h", $time, ev, fv);
        errors++;
      end
      if (le !== el) begin
        $display("%0t: live_entries expected %0d actual %0d", $time, el, le);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [KEY_W-1:0] key = '0;
  logic [VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [VAL_W-1:0] found_value;
  logic [LIVE_W-1:0] live_entries;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned clears = 0;
  logic [KEY_W-1:0] key_pool[16];
  hash_map_scoreboard sb;

  open_addressing_hash_map_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .key(key),
    .value(value), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .found_value(found_value), .live_entries(live_entries)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("tb_open_addressing_hash_map_unit: FAIL");
      $finish;
    end
  end

  // response side: check on acceptance, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_response(status, found_value, live_entries);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays up after acceptance until the next request or an idle cycle replaces it
  task automatic send_request(logic [1:0] rt, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    key <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rt, k, v);
    sent++;
    if (rt == REQ_CLEAR) clears++;
  endtask

  // waits until every response is in, plus a margin for the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.sts_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_hash_select(bit sel);
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.direct_hash = sel;
  endtask

  task automatic random_phase(int n, int idle, int stall_pct);
    logic [1:0] rt;
    logic [KEY_W-1:0] k;
    int r;
    send_idle_pct = idle;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) rt = REQ_PUT;
      else if (r < 75) rt = REQ_GET;
      else if (r < 99) rt = REQ_REMOVE;
      else rt = REQ_CLEAR;
      // mostly reuse a small key pool so gets and removes hit
      if ($urandom_range(99) < 80) k = key_pool[$urandom_range(15)];
      else k = $urandom;
      send_request(rt, k, $urandom);
    end
    send_idle_pct = 0;
    drain();
  endtask

  initial begin
    sb = new();
    sb.clear_table();
    sb.direct_hash = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    // colliding keys under the direct hash, then the two extremes
    key_pool[0] = 32'h0000_0005;
    key_pool[1] = 32'h0000_0405;
    key_pool[2] = 32'h0000_0805;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // directed: empty table, extremes, collisions, tombstone reuse, clear
    send_request(REQ_GET, 32'h0, 32'h0);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_PUT, 32'h0, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_GET, 32'h0, 32'h1234_5678);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_PUT, 32'h0, 32'hA5A5_5A5A);
    send_request(REQ_GET, 32'h0, 32'h0);
    send_request(REQ_GET, 32'h1234_5678, 32'h0);
    send_request(REQ_REMOVE, 32'h0, 32'h0);
    send_request(REQ_REMOVE, 32'h0, 32'h0);
    send_request(REQ_CLEAR, 32'h0, 32'h0);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    drain();
    write_hash_select(1'b1);
    send_request(REQ_PUT, 32'h5, 32'h11);
    send_request(REQ_PUT, 32'h405, 32'h22);
    send_request(REQ_PUT, 32'h805, 32'h33);
    send_request(REQ_REMOVE, 32'h405, 32'h0);
    send_request(REQ_GET, 32'h805, 32'h0);
    send_request(REQ_PUT, 32'hC05, 32'h44);
    send_request(REQ_GET, 32'hC05, 32'h0);
    send_request(REQ_GET, 32'h405, 32'h0);
    send_request(REQ_CLEAR, 32'h0, 32'h0);
    drain();

    random_phase(200, 0, 0);
    write_hash_select(1'b0);
    random_phase(200, 73, 0);
    write_hash_select(1'b1);
    random_phase(180, 0, 73);
    write_hash_select(1'b0);
    random_phase(170, 17, 17);
    drain();

    $display("requests sent %0d, responses checked %0d, clears %0d, both hash modes",
             sent, sb.checked, clears);
    if (sb.errors == 0 && sb.sts_fifo.size() == 0) begin
      $display("tb_open_addressing_hash_map_unit: PASS");
    end else begin
      $display("tb_open_addressing_hash_map_unit: FAIL");
    end
    $finish;
  end
endmodule
